@@ design/ohlc_pkg.sv @@
package ohlc_pkg;

    localparam int INST_W       = 6;
    localparam int PORT_PRICE_W = 31;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic [INST_W-1:0]       instrument;
        logic [PORT_PRICE_W-1:0] price;
    } tick_t;

    typedef struct packed {
        logic [INST_W-1:0]       bar_instrument;
        logic [PORT_PRICE_W-1:0] open_price;
        logic [PORT_PRICE_W-1:0] high_price;
        logic [PORT_PRICE_W-1:0] low_price;
        logic [PORT_PRICE_W-1:0] close_price;
        logic                    last_bar;
    } bar_t;

    // controller to datapath
    typedef struct packed {
        logic take;       // input ready
        logic tick_rd;    // read table at the captured instrument
        logic tick_wr;    // write the updated bar back
        logic walk_clr;   // restart the flush walk at entry zero
        logic walk_rd;    // read table at the walk index
        logic walk_load;  // load output register, clear entry, advance
    } ohlc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic in_flush;
        logic in_range;
        logic out_free;
        logic walk_last;
    } ohlc_status_t;

endpackage

@@ design/ohlc_stream_if.sv @@
interface ohlc_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/ohlc_ctrl.sv @@
module ohlc_ctrl
    import ohlc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ohlc_status_t status,
    output ohlc_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_TICK_RD = 3'd1;
    localparam logic [2:0] S_TICK_WR = 3'd2;
    localparam logic [2:0] S_WALK_RD = 3'd3;
    localparam logic [2:0] S_WALK_LD = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (status.in_valid)
                begin
                    if (status.in_flush)
                    begin
                        cmd.walk_clr = 1'b1;
                        state_next   = S_WALK_RD;
                    end
                    else if (status.in_range)
                    begin
                        state_next = S_TICK_RD;
                    end
                end
            end
            S_TICK_RD:
            begin
                cmd.tick_rd = 1'b1;
                state_next  = S_TICK_WR;
            end
            S_TICK_WR:
            begin
                cmd.tick_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_LD;
            end
            S_WALK_LD:
            begin
                // hold until the output register can take the bar
                if (status.out_free)
                begin
                    cmd.walk_load = 1'b1;
                    state_next    = status.walk_last ? S_IDLE : S_WALK_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/ohlc_dp.sv @@
module ohlc_dp
    import ohlc_pkg::*;
#(
    parameter int NUM_INSTRUMENTS = 64,
    parameter int PRICE_WIDTH     = 31
)
(
    input  logic          clk,
    input  logic          rst_n,
    ohlc_stream_if.sink   ticks,
    ohlc_stream_if.source bars,
    input  ohlc_cmd_t     cmd,
    output ohlc_status_t  status
);

    localparam int IDX_W = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;

    typedef struct packed {
        logic [PRICE_WIDTH-1:0] open_p;
        logic [PRICE_WIDTH-1:0] high_p;
        logic [PRICE_WIDTH-1:0] low_p;
        logic [PRICE_WIDTH-1:0] close_p;
    } entry_t;

    entry_t               mem [NUM_INSTRUMENTS];
    entry_t               rd_data_reg;
    entry_t               wr_data;
    logic [IDX_W-1:0]     rd_addr;

    logic [NUM_INSTRUMENTS-1:0] seen_reg;
    logic [NUM_INSTRUMENTS-1:0] seen_next;

    logic [IDX_W-1:0]       item_addr_reg;
    logic [PRICE_WIDTH-1:0] item_px_reg;
    logic [IDX_W-1:0]       walk_cnt_reg;
    logic [IDX_W-1:0]       walk_cnt_next;

    logic out_valid_reg;
    logic out_valid_next;
    bar_t out_data_reg;
    bar_t out_data_next;

    logic accept;
    logic walk_seen;

    assign ticks.ready = cmd.take;
    assign accept      = ticks.valid && cmd.take;

    assign status.in_valid  = ticks.valid;
    assign status.in_flush  = (ticks.data.mode == MODE_FLUSH);
    assign status.in_range  = ({1'b0, ticks.data.instrument} < (INST_W + 1)'(NUM_INSTRUMENTS));
    assign status.out_free  = !out_valid_reg || bars.ready;
    assign status.walk_last = (walk_cnt_reg == IDX_W'(NUM_INSTRUMENTS - 1));

    // capture the tick fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_addr_reg <= ticks.data.instrument[IDX_W-1:0];
            item_px_reg   <= PRICE_WIDTH'(ticks.data.price);
        end
    end

    // bar table, one write and one registered read port
    assign rd_addr = cmd.tick_rd ? item_addr_reg : walk_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.tick_wr)
        begin
            mem[item_addr_reg] <= wr_data;
        end
        if (cmd.tick_rd || cmd.walk_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // first tick of the interval seeds all four prices
    always_comb
    begin
        if (!seen_reg[item_addr_reg])
        begin
            wr_data.open_p  = item_px_reg;
            wr_data.high_p  = item_px_reg;
            wr_data.low_p   = item_px_reg;
            wr_data.close_p = item_px_reg;
        end
        else
        begin
            wr_data.open_p  = rd_data_reg.open_p;
            wr_data.high_p  = (item_px_reg > rd_data_reg.high_p) ? item_px_reg
                                                                 : rd_data_reg.high_p;
            wr_data.low_p   = (item_px_reg < rd_data_reg.low_p) ? item_px_reg
                                                                : rd_data_reg.low_p;
            wr_data.close_p = item_px_reg;
        end
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (cmd.tick_wr)
        begin
            seen_next[item_addr_reg] = 1'b1;
        end
        if (cmd.walk_load)
        begin
            seen_next[walk_cnt_reg] = 1'b0;
        end
    end

    always_comb
    begin
        walk_cnt_next = walk_cnt_reg;
        if (cmd.walk_clr)
        begin
            walk_cnt_next = '0;
        end
        else if (cmd.walk_load)
        begin
            walk_cnt_next = walk_cnt_reg + 1'b1;
        end
    end

    assign walk_seen = seen_reg[walk_cnt_reg];

    always_comb
    begin
        out_data_next                = out_data_reg;
        out_valid_next               = out_valid_reg;
        if (cmd.walk_load)
        begin
            out_valid_next               = 1'b1;
            out_data_next.bar_instrument = INST_W'(walk_cnt_reg);
            out_data_next.last_bar       = status.walk_last;
            if (walk_seen)
            begin
                out_data_next.open_price  = PORT_PRICE_W'(rd_data_reg.open_p);
                out_data_next.high_price  = PORT_PRICE_W'(rd_data_reg.high_p);
                out_data_next.low_price   = PORT_PRICE_W'(rd_data_reg.low_p);
                out_data_next.close_price = PORT_PRICE_W'(rd_data_reg.close_p);
            end
            else
            begin
                out_data_next.open_price  = '0;
                out_data_next.high_price  = '0;
                out_data_next.low_price   = '0;
                out_data_next.close_price = '0;
            end
        end
        else if (bars.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            walk_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            walk_cnt_reg  <= walk_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign bars.valid = out_valid_reg;
    assign bars.data  = out_data_reg;

endmodule

@@ design/ohlc_bar_aggregator.sv @@
// Channel   Direction  Payload  Content
// ticks     in         tick_t   mode, instrument, price
// bars      out        bar_t    bar_instrument, open/high/low/close_price, last_bar
//
// A tick passes through accept, table read and table write (read-modify-write on
// the bar table); the next tick is accepted only after the write.
// A flush walks every entry in turn: each entry needs a table read, then a load
// into the output register.
// Reset clears the per-entry valid bits at once; no clearing pass.
// A stalled output holds the walk; ticks are accepted while the last bar waits.
module ohlc_bar_aggregator
    import ohlc_pkg::*;
#(
    parameter int NUM_INSTRUMENTS = 64,
    parameter int PRICE_WIDTH     = 31
)
(
    input  logic          clk,
    input  logic          rst_n,
    ohlc_stream_if.sink   ticks,
    ohlc_stream_if.source bars
);

    ohlc_cmd_t    cmd;
    ohlc_status_t status;

    ohlc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    ohlc_dp #(
        .NUM_INSTRUMENTS (NUM_INSTRUMENTS),
        .PRICE_WIDTH     (PRICE_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ticks  (ticks),
        .bars   (bars),
        .cmd    (cmd),
        .status (status)
    );

endmodule
